// File: rtl/core/wnm_pkg.sv
`timescale 1ns / 1ps

package wnm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 6;

  localparam logic [7:0] STAR_BYTE     = 8'h2A;
  localparam logic [7:0] QUESTION_BYTE = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] REG_PAT0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LAST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLEN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ALL = 3'd5;

  typedef struct packed {
    logic [7:0] name_char;
    logic       has_char;
    logic       name_end;
  } item_t;

endpackage

// File: rtl/core/wnm_step.sv
`timescale 1ns / 1ps

module wnm_step #(
  parameter int PATTERN_CHARS = 32
) (
  input  logic [PATTERN_CHARS*8-1:0]          pattern,
  input  logic [$clog2(PATTERN_CHARS+1)-1:0]  len,
  input  logic                                match_all,
  input  logic [PATTERN_CHARS:0]              pos,
  input  wnm_pkg::item_t                      item,
  output logic [PATTERN_CHARS:0]              pos_nxt,
  output logic                                matched
);
  import wnm_pkg::*;

  localparam int NPOS = PATTERN_CHARS + 1;
  localparam int IW   = $clog2(NPOS);

  // prop[j] set when pattern byte j-1 is an in-use star; closure is a prefix OR
  function automatic logic [NPOS-1:0] star_closure(input logic [NPOS-1:0] v,
                                                    input logic [NPOS-1:0] prop);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] p;
    g = v;
    p = prop;
    for (int d = 1; d < NPOS; d = d * 2) begin
      g = g | (p & (g << d));
      p = p & (p << d);
    end
    return g;
  endfunction

  logic [PATTERN_CHARS-1:0] is_star;
  logic [PATTERN_CHARS-1:0] is_step;
  logic [NPOS-1:0]          prop;
  logic [NPOS-1:0]          clo_in;
  logic [NPOS-1:0]          adv;
  logic [NPOS-1:0]          after_char;
  logic [NPOS-1:0]          clo_end;

  always_comb begin
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      is_star[i] = (len > IW'(i)) && (pattern[i*8 +: 8] == STAR_BYTE);
      is_step[i] = (len > IW'(i)) && (pattern[i*8 +: 8] != STAR_BYTE) &&
                   ((pattern[i*8 +: 8] == QUESTION_BYTE) ||
                    (pattern[i*8 +: 8] == item.name_char));
    end
    prop = {is_star, 1'b0};
  end

  always_comb begin
    clo_in = star_closure(pos, prop);
    adv    = '0;
    for (int i = 0; i < PATTERN_CHARS; i++) begin
      adv[i]   = adv[i] | (clo_in[i] & is_star[i]);
      adv[i+1] = clo_in[i] & is_step[i];
    end
    after_char = item.has_char ? adv : pos;
    clo_end    = star_closure(after_char, prop);
  end

  always_comb begin
    matched = match_all | clo_end[len];
    if (item.name_end) begin
      pos_nxt = NPOS'(1);
    end else begin
      pos_nxt = after_char;
    end
  end

endmodule

// File: rtl/core/wildcard_name_matcher_top.sv
`timescale 1ns / 1ps
// Only a name-ending word yields a result; it passes the item register, then the result register.
// Throughput: one word per cycle while in_stall is low; the position vector takes one full update
//   (star closure, byte step, closure again) per cycle in a single stage.
// Only an ending word held behind a stalled result stalls the input.
// Reset (rst_n low, synchronous): pattern cleared, length 0, match_all set,
//   only position zero active, pipeline empty.

module wildcard_name_matcher_top #(
  parameter int PATTERN_CHARS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_name_char,
  input  logic                            in_has_char,
  input  logic                            in_name_end,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_matched,
  input  logic                            cfg_we,
  input  logic [wnm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wnm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wnm_pkg::*;

  localparam int NPOS = PATTERN_CHARS + 1;
  localparam int IW   = $clog2(NPOS);

  logic [PATTERN_CHARS*8-1:0] pat_r, pat_nxt;
  logic [LEN_W-1:0]           plen_r, plen_nxt;
  logic                       match_all_r, match_all_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  item_t                      s1_item_r, s1_item_nxt;
  logic [NPOS-1:0]            pos_r, pos_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_matched_r, out_matched_nxt;

  logic [IW-1:0]   len_used;
  logic [NPOS-1:0] step_pos;
  logic            step_matched;
  logic            s1_adv;
  logic            in_acc;
  logic            s1_done;

  assign len_used = (plen_r > LEN_W'(PATTERN_CHARS)) ? IW'(PATTERN_CHARS) : plen_r[IW-1:0];

  wnm_step #(
    .PATTERN_CHARS(PATTERN_CHARS)
  ) u_step (
    .pattern   (pat_r),
    .len       (len_used),
    .match_all (match_all_r),
    .pos       (pos_r),
    .item      (s1_item_r),
    .pos_nxt   (step_pos),
    .matched   (step_matched)
  );

  assign s1_adv    = s1_valid_r && !(s1_item_r.name_end && out_valid_r && out_stall);
  assign s1_done   = s1_adv && s1_item_r.name_end;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  always_comb begin
    pat_nxt       = pat_r;
    plen_nxt      = plen_r;
    match_all_nxt = match_all_r;
    if (cfg_we) begin
      if (cfg_index <= REG_PAT_LAST) begin
        for (int b = 0; b < PATTERN_CHARS; b++) begin
          if (cfg_index == REG_PAT0 + CFG_IDX_W'(b / 8)) begin
            pat_nxt[b*8 +: 8] = cfg_wdata[(b % 8)*8 +: 8];
          end
        end
      end else if (cfg_index == REG_PLEN) begin
        plen_nxt = cfg_wdata[LEN_W-1:0];
      end else if (cfg_index == REG_MATCH_ALL) begin
        match_all_nxt = cfg_wdata[0];
      end
    end
  end

  always_comb begin
    s1_valid_nxt    = s1_valid_r;
    s1_item_nxt     = s1_item_r;
    pos_nxt         = pos_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      pos_nxt      = step_pos;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_item_nxt  = '{name_char: in_name_char, has_char: in_has_char,
                       name_end: in_name_end};
    end
    if (s1_done) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = step_matched;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= '0;
      plen_r      <= '0;
      match_all_r <= 1'b1;
      s1_valid_r  <= 1'b0;
      pos_r       <= NPOS'(1);
      out_valid_r <= 1'b0;
    end else begin
      pat_r       <= pat_nxt;
      plen_r      <= plen_nxt;
      match_all_r <= match_all_nxt;
      s1_valid_r  <= s1_valid_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r     <= s1_item_nxt;
    out_matched_r <= out_matched_nxt;
  end

endmodule

// File: rtl/core/wnm_checker.sv
`timescale 1ns / 1ps

module wnm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_matched
);

  // held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched))
    else $error("result word changed while stalled");

  // input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result backpressure");

  // a result is only dropped once taken
  a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) && $past(rst_n) |-> $past(!out_stall))
    else $error("result word lost");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind wildcard_name_matcher_top wnm_checker u_wnm_checker (.*);
